[sv/gnms_pkg.sv]
// gnms_pkg: shared types, codes and helpers for the grid nearest-match search.
// No dependencies; imported by gnms_walker, grid_nearest_match_search, gnms_checker and the testbench.
package gnms_pkg;

	localparam int COORD_W    = 6;
	localparam int KIND_W     = 4;
	localparam int KIND_PAD_W = 8;
	localparam int SCOORD_W   = COORD_W + 2;

	typedef logic [COORD_W-1:0]          coord_t;
	typedef logic signed [SCOORD_W-1:0]  scoord_t;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_READ   = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_START_X = 2'd0,
		CFG_START_Y = 2'd1,
		CFG_END_X   = 2'd2,
		CFG_END_Y   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} bounds_t;

	typedef struct packed {
		logic   done;
		logic   found;
		coord_t fx;
		coord_t fy;
	} walk_res_t;

	function automatic scoord_t to_s(coord_t v);
		return scoord_t'({2'b00, v});
	endfunction

	// coordinate lies inside the grid and inside [lo, hi]
	function automatic logic coord_ok(scoord_t v, coord_t lo, coord_t hi, int lim);
		return (v >= 0) && (int'(v) < lim) && (v >= to_s(lo)) && (v <= to_s(hi));
	endfunction

endpackage

[sv/gnms_grid_mem.sv]
// gnms_grid_mem: tile kind store, one write port and one registered read port.
// No package dependency.
module gnms_grid_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/gnms_walker.sv]
// gnms_walker: ring-by-ring probe generator and match check for the search.
// Depends on gnms_pkg; reads through the grid memory's registered port.
module gnms_walker import gnms_pkg::*; #(
	parameter int GRID_W    = 64,
	parameter int GRID_H    = 64,
	parameter int KIND_BITS = 4,
	parameter int AW        = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  coord_t               cx,
	input  coord_t               cy,
	input  logic [KIND_BITS-1:0] kind,
	input  bounds_t              bnd,
	input  logic [KIND_BITS-1:0] rdata,
	output logic [AW-1:0]        raddr,
	output walk_res_t            res
);

	logic                 active_q;
	logic                 gen_end_q;
	logic [COORD_W:0]     r_q;
	scoord_t              x_q, y_q, cx_q, cy_q;
	logic [KIND_BITS-1:0] kind_q;
	logic                 pv_s1;
	coord_t               px_s1, py_s1;

	scoord_t r_s, lo_x, hi_x, lo_y, hi_y;
	logic    x_ok, y_ok, edge_col, covered, match, col_last, ring_last, step, empty;

	always_comb begin
		r_s       = scoord_t'({1'b0, r_q});
		lo_x      = cx_q - r_s;
		hi_x      = cx_q + r_s;
		lo_y      = cy_q - r_s;
		hi_y      = cy_q + r_s;
		x_ok      = coord_ok(x_q, bnd.start_x, bnd.end_x, GRID_W);
		y_ok      = coord_ok(y_q, bnd.start_y, bnd.end_y, GRID_H);
		edge_col  = (x_q == lo_x) || (x_q == hi_x);
		covered   = (lo_x <= to_s(bnd.start_x)) && (hi_x >= to_s(bnd.end_x)) &&
			(lo_y <= to_s(bnd.start_y)) && (hi_y >= to_s(bnd.end_y));
		match     = pv_s1 && (rdata == kind_q);
		col_last  = !x_ok || (y_q == hi_y);
		ring_last = col_last && (x_q == hi_x);
		step      = active_q && !gen_end_q && !match;
		empty     = (bnd.start_x > bnd.end_x) || (bnd.start_y > bnd.end_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			gen_end_q <= 1'b0;
			pv_s1     <= 1'b0;
		end else if (start) begin
			active_q  <= 1'b1;
			gen_end_q <= empty;
			pv_s1     <= 1'b0;
		end else if (active_q) begin
			if (match || gen_end_q) begin
				active_q <= 1'b0;
			end
			pv_s1 <= step && x_ok && y_ok;
			if (step && ring_last && covered) begin
				gen_end_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= '0;
			x_q    <= to_s(cx);
			y_q    <= to_s(cy);
			cx_q   <= to_s(cx);
			cy_q   <= to_s(cy);
			kind_q <= kind;
		end else if (step) begin
			if (ring_last) begin
				if (!covered) begin
					r_q <= r_q + 1'b1;
					x_q <= lo_x - scoord_t'(1);
					y_q <= lo_y - scoord_t'(1);
				end
			end else if (col_last) begin
				x_q <= x_q + scoord_t'(1);
				y_q <= lo_y;
			end else begin
				y_q <= edge_col ? y_q + scoord_t'(1) : hi_y;
			end
		end
		px_s1 <= x_q[COORD_W-1:0];
		py_s1 <= y_q[COORD_W-1:0];
	end

	assign raddr     = AW'(int'(y_q[COORD_W-1:0]) * GRID_W + int'(x_q[COORD_W-1:0]));
	assign res.done  = active_q && (match || gen_end_q);
	assign res.found = match;
	assign res.fx    = px_s1;
	assign res.fy    = py_s1;

endmodule

[sv/grid_nearest_match_search.sv]
// grid_nearest_match_search: top level, request sequencer, bounds registers, output beat.
// Depends on gnms_pkg, gnms_grid_mem and gnms_walker.
//
// channel | direction | handshake           | payload
// in      | in        | in_valid / in_stall   | req_type pos_x pos_y tile_kind
// out     | out       | out_valid / out_stall | hit found_x found_y read_kind
// cfg     | in        | cfg_we                | cfg_index cfg_data
//
// Write or unused request goes to ST_EMIT; read: ST_READ (one memory read), then ST_EMIT.
// Search: ST_SEARCH walks up to 4R(R+1)+1 ring steps for final radius R, then ST_EMIT;
// each step is one read of the grid memory, so the memory port sets the pace.
// After reset the grid is cleared one cell a cycle, with in_stall high throughout.
// One request at a time; a new beat is taken while the previous result waits on out_stall.
module grid_nearest_match_search import gnms_pkg::*; #(
	parameter int GRID_W    = 64,
	parameter int GRID_H    = 64,
	parameter int KIND_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  coord_t             pos_x,
	input  coord_t             pos_y,
	input  logic [KIND_W-1:0]  tile_kind,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output coord_t             found_x,
	output coord_t             found_y,
	output logic [KIND_W-1:0]  read_kind,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  coord_t             cfg_data
);

	localparam int DEPTH = GRID_W * GRID_H;
	localparam int AW    = $clog2(DEPTH);

	state_t state_q, state_d;
	bounds_t bnd_q;
	logic [AW-1:0] clr_cnt_q;
	logic res_hit_q;
	coord_t res_x_q, res_y_q;
	logic [KIND_W-1:0] res_kind_q;
	logic out_valid_q, hit_q;
	coord_t found_x_q, found_y_q;
	logic [KIND_W-1:0] read_kind_q;

	req_t req;
	logic pos_ok, clr_last, slot_free, walk_start;
	logic [AW-1:0] pos_addr, walk_raddr, mem_waddr, mem_raddr;
	logic mem_we;
	logic [KIND_BITS-1:0] mem_wdata, mem_rdata, kind_in;
	logic [KIND_PAD_W-1:0] kin_pad, rd_pad;
	logic [KIND_W-1:0] rd_kind;
	walk_res_t walk_res;

	always_comb begin
		req       = req_t'(req_type);
		pos_ok    = coord_ok(to_s(pos_x), bnd_q.start_x, bnd_q.end_x, GRID_W) &&
			coord_ok(to_s(pos_y), bnd_q.start_y, bnd_q.end_y, GRID_H);
		pos_addr  = AW'(int'(pos_y) * GRID_W + int'(pos_x));
		clr_last  = (clr_cnt_q == AW'(DEPTH - 1));
		slot_free = !out_valid_q || !out_stall;
		kin_pad   = '0;
		kin_pad[KIND_W-1:0] = tile_kind;
		kind_in   = kin_pad[KIND_BITS-1:0];
		rd_pad    = '0;
		rd_pad[KIND_BITS-1:0] = mem_rdata;
		rd_kind   = rd_pad[KIND_W-1:0];
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		mem_we     = 1'b0;
		mem_waddr  = clr_cnt_q;
		mem_wdata  = '0;
		mem_raddr  = pos_addr;
		walk_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (req)
						REQ_WRITE: begin
							mem_we    = pos_ok;
							mem_waddr = pos_addr;
							mem_wdata = kind_in;
							state_d   = ST_EMIT;
						end
						REQ_READ:   state_d = ST_READ;
						REQ_SEARCH: begin
							walk_start = 1'b1;
							state_d    = ST_SEARCH;
						end
						REQ_NONE:   state_d = ST_EMIT;
					endcase
				end
			end
			ST_READ: state_d = ST_EMIT;
			ST_SEARCH: begin
				mem_raddr = walk_raddr;
				if (walk_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			bnd_q       <= '{start_x: '0, start_y: '0, end_x: '1, end_y: '1};
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (slot_free) begin
				out_valid_q <= (state_q == ST_EMIT);
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_START_X: bnd_q.start_x <= cfg_data;
					CFG_START_Y: bnd_q.start_y <= cfg_data;
					CFG_END_X:   bnd_q.end_x   <= cfg_data;
					CFG_END_Y:   bnd_q.end_y   <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			res_hit_q  <= ((req == REQ_WRITE) || (req == REQ_READ)) && pos_ok;
			res_x_q    <= pos_x;
			res_y_q    <= pos_y;
			res_kind_q <= '0;
		end
		if (state_q == ST_READ && res_hit_q) begin
			res_kind_q <= rd_kind;
		end
		if (state_q == ST_SEARCH && walk_res.done && walk_res.found) begin
			res_hit_q <= 1'b1;
			res_x_q   <= walk_res.fx;
			res_y_q   <= walk_res.fy;
		end
		if (state_q == ST_EMIT && slot_free) begin
			hit_q       <= res_hit_q;
			found_x_q   <= res_x_q;
			found_y_q   <= res_y_q;
			read_kind_q <= res_kind_q;
		end
	end

	gnms_grid_mem #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (KIND_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	gnms_walker #(
		.GRID_W   (GRID_W),
		.GRID_H   (GRID_H),
		.KIND_BITS(KIND_BITS),
		.AW       (AW)
	) u_walker (
		.clk   (clk),
		.arst_n(arst_n),
		.start (walk_start),
		.cx    (pos_x),
		.cy    (pos_y),
		.kind  (kind_in),
		.bnd   (bnd_q),
		.rdata (mem_rdata),
		.raddr (walk_raddr),
		.res   (walk_res)
	);

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign found_x   = found_x_q;
	assign found_y   = found_y_q;
	assign read_kind = read_kind_q;

endmodule

[sv/gnms_checker.sv]
// gnms_checker: port-level checks on the grid nearest-match search, bound to the top level.
// Depends on gnms_pkg and grid_nearest_match_search.
module gnms_checker import gnms_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input coord_t            found_x,
	input coord_t            found_y,
	input logic [KIND_W-1:0] read_kind
);

	// held output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(found_x) &&
			$stable(found_y) && $stable(read_kind))
		else $error("output beat changed while stalled");

	// one request in flight: the cycle after an accepted beat the input is stalled
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input beat accepted while a request is in flight");

	// a miss never carries a kind
	a_miss_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> read_kind == '0)
		else $error("read_kind nonzero on a miss");

	// a result never follows a cycle in which the input was open and idle and no result was held
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !in_valid && !out_valid |=> !out_valid)
		else $error("result beat without a request");

endmodule

bind grid_nearest_match_search gnms_checker u_gnms_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for grid_nearest_match_search. Holds its own tile map and
// search model, drives requests and config writes, and checks every result beat in order.
// Depends on gnms_pkg and the grid_nearest_match_search RTL.
module testbench;
	import gnms_pkg::*;

	localparam int MAP_W       = 64;
	localparam int MAP_H       = 64;
	localparam int QUIET_LIMIT = 80000;

	typedef struct {
		req_t              op;
		coord_t            x;
		coord_t            y;
		logic [KIND_W-1:0] kind;
	} tile_req_t;

	typedef struct {
		logic              hit;
		coord_t            fx;
		coord_t            fy;
		logic [KIND_W-1:0] kind;
	} tile_ans_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type  = '0;
	coord_t            pos_x     = '0;
	coord_t            pos_y     = '0;
	logic [KIND_W-1:0] tile_kind = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              hit;
	coord_t            found_x;
	coord_t            found_y;
	logic [KIND_W-1:0] read_kind;
	logic              cfg_we    = 1'b0;
	logic [1:0]        cfg_index = '0;
	coord_t            cfg_data  = '0;

	tile_req_t         req_backlog[$];
	tile_ans_t         answers_due[$];
	tile_req_t         cur_req;
	logic [KIND_W-1:0] tile_map[MAP_W*MAP_H];
	int                lim_x0 = 0;
	int                lim_y0 = 0;
	int                lim_x1 = 63;
	int                lim_y1 = 63;
	bit                steady = 1'b0;
	bit                in_took = 1'b0;
	bit                out_took = 1'b0;
	int                in_gap = 0;
	int                out_wait = 3;
	int                quiet_cycles = 0;
	int                fault_count = 0;

	grid_nearest_match_search i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.tile_kind (tile_kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.found_x   (found_x),
		.found_y   (found_y),
		.read_kind (read_kind),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		for (int i = 0; i < MAP_W * MAP_H; i++)
			tile_map[i] = '0;
	end

	function automatic int map_idx(int x, int y);
		return y * MAP_W + x;
	endfunction

	function automatic bit cell_open(int x, int y);
		return x >= 0 && y >= 0 && x < MAP_W && y < MAP_H &&
			x >= lim_x0 && x <= lim_x1 && y >= lim_y0 && y <= lim_y1;
	endfunction

	function automatic bit cell_holds(int x, int y, logic [KIND_W-1:0] k);
		return cell_open(x, y) && tile_map[map_idx(x, y)] == k;
	endfunction

	// rings of growing radius, column-major, rows low to high
	function automatic bit nearest_match(int cx, int cy, logic [KIND_W-1:0] k,
			output int fx, output int fy);
		fx = cx;
		fy = cy;
		if (lim_x0 > lim_x1 || lim_y0 > lim_y1)
			return 1'b0;
		for (int r = 0; r <= 2 * MAP_W; r++) begin
			for (int x = cx - r; x <= cx + r; x++) begin
				if (x == cx - r || x == cx + r) begin
					for (int y = cy - r; y <= cy + r; y++) begin
						if (cell_holds(x, y, k)) begin
							fx = x;
							fy = y;
							return 1'b1;
						end
					end
				end else begin
					if (cell_holds(x, cy - r, k)) begin
						fx = x;
						fy = cy - r;
						return 1'b1;
					end
					if (r != 0 && cell_holds(x, cy + r, k)) begin
						fx = x;
						fy = cy + r;
						return 1'b1;
					end
				end
			end
			if (cx - r <= lim_x0 && cx + r >= lim_x1 && cy - r <= lim_y0 && cy + r >= lim_y1)
				break;
		end
		return 1'b0;
	endfunction

	function automatic tile_ans_t predict_answer(tile_req_t q);
		tile_ans_t a;
		int mx;
		int my;
		a.hit  = 1'b0;
		a.fx   = q.x;
		a.fy   = q.y;
		a.kind = '0;
		case (q.op)
			REQ_WRITE: begin
				if (cell_open(q.x, q.y)) begin
					tile_map[map_idx(q.x, q.y)] = q.kind;
					a.hit = 1'b1;
				end
			end
			REQ_READ: begin
				if (cell_open(q.x, q.y)) begin
					a.hit  = 1'b1;
					a.kind = tile_map[map_idx(q.x, q.y)];
				end
			end
			REQ_SEARCH: begin
				if (nearest_match(q.x, q.y, q.kind, mx, my)) begin
					a.hit = 1'b1;
					a.fx  = coord_t'(mx);
					a.fy  = coord_t'(my);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic queue_req(req_t op, int x, int y, int k);
		tile_req_t q;
		q.op   = op;
		q.x    = coord_t'(x);
		q.y    = coord_t'(y);
		q.kind = k[KIND_W-1:0];
		req_backlog = {req_backlog, q};
	endtask

	task automatic cfg_write(cfg_idx_t idx, int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= coord_t'(v);
		case (idx)
			CFG_START_X: lim_x0 = v;
			CFG_START_Y: lim_y0 = v;
			CFG_END_X:   lim_x1 = v;
			CFG_END_Y:   lim_y1 = v;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(int x0, int y0, int x1, int y1);
		cfg_write(CFG_START_X, x0);
		cfg_write(CFG_START_Y, y0);
		cfg_write(CFG_END_X, x1);
		cfg_write(CFG_END_Y, y1);
	endtask

	task automatic random_window(int span);
		int x0;
		int y0;
		int x1;
		int y1;
		x0 = $urandom_range(0, 63);
		y0 = $urandom_range(0, 63);
		x1 = x0 + $urandom_range(0, span);
		y1 = y0 + $urandom_range(0, span);
		set_window(x0, y0, (x1 > 63) ? 63 : x1, (y1 > 63) ? 63 : y1);
	endtask

	// wait for every beat to be taken and answered, then let the block settle
	task automatic drain();
		while (req_backlog.size() != 0 || in_valid || answers_due.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic int near_coord(int lo, int hi);
		int a;
		int b;
		if (lo > hi || $urandom_range(0, 7) == 0)
			return $urandom_range(0, 63);
		a = (lo - 3 < 0) ? 0 : lo - 3;
		b = (hi + 3 > 63) ? 63 : hi + 3;
		return $urandom_range(a, b);
	endfunction

	// when the window is not empty, half the searches look for a kind that sits somewhere in it
	function automatic int search_kind();
		if (lim_x0 <= lim_x1 && lim_y0 <= lim_y1 && $urandom_range(0, 1) == 1)
			return tile_map[map_idx($urandom_range(lim_x0, lim_x1), $urandom_range(lim_y0, lim_y1))];
		return $urandom_range(0, 15);
	endfunction

	task automatic random_burst(int n);
		int pick;
		req_t op;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 19);
			op = (pick < 7) ? REQ_WRITE : (pick < 12) ? REQ_READ :
				(pick < 19) ? REQ_SEARCH : REQ_NONE;
			queue_req(op, near_coord(lim_x0, lim_x1), near_coord(lim_y0, lim_y1),
				(op == REQ_SEARCH) ? search_kind() : $urandom_range(0, 15));
		end
	endtask

	// request driver: predicts each beat as it is taken
	always @(negedge clk) begin
		if (in_valid && in_took) begin
			answers_due = {answers_due, predict_answer(cur_req)};
			in_gap = steady ? 0 : $urandom_range(0, 7);
		end
		if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (req_backlog.size() != 0) begin
				cur_req = req_backlog.pop_front();
				in_valid  <= 1'b1;
				req_type  <= cur_req.op;
				pos_x     <= cur_req.x;
				pos_y     <= cur_req.y;
				tile_kind <= cur_req.kind;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (out_took)
			out_wait = steady ? 0 : $urandom_range(0, 7);
		if (out_wait > 0) begin
			out_stall <= 1'b1;
			out_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		tile_ans_t want;
		in_took  <= arst_n && in_valid && !in_stall;
		out_took <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				note_fault($sformatf("result beat with none due: hit %0d x %0d y %0d kind %0d",
					hit, found_x, found_y, read_kind));
			end else begin
				want = answers_due.pop_front();
				if (want.hit !== hit || want.fx !== found_x || want.fy !== found_y ||
						want.kind !== read_kind)
					note_fault($sformatf({"mismatch: expected hit %0d x %0d y %0d kind %0d,",
						" got hit %0d x %0d y %0d kind %0d"}, want.hit, want.fx, want.fy,
						want.kind, hit, found_x, found_y, read_kind));
			end
		end
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL grid_nearest_match_search");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window, whole map
		queue_req(REQ_READ, 0, 0, 0);
		queue_req(REQ_WRITE, 0, 0, 15);
		queue_req(REQ_WRITE, 63, 63, 9);
		queue_req(REQ_WRITE, 31, 33, 5);
		queue_req(REQ_WRITE, 33, 31, 5);
		queue_req(REQ_READ, 63, 63, 0);
		queue_req(REQ_SEARCH, 32, 32, 5);
		queue_req(REQ_SEARCH, 0, 0, 15);
		queue_req(REQ_SEARCH, 0, 63, 9);
		queue_req(REQ_SEARCH, 63, 0, 7);
		queue_req(REQ_NONE, 63, 63, 15);
		queue_req(REQ_SEARCH, 0, 0, 0);
		drain();

		// small window, edges just inside and outside
		set_window(10, 20, 25, 30);
		queue_req(REQ_WRITE, 9, 20, 3);
		queue_req(REQ_WRITE, 25, 30, 3);
		queue_req(REQ_WRITE, 26, 30, 3);
		queue_req(REQ_READ, 10, 31, 0);
		queue_req(REQ_SEARCH, 0, 0, 3);
		queue_req(REQ_SEARCH, 50, 50, 5);
		drain();

		set_window(63, 63, 63, 63);
		queue_req(REQ_WRITE, 63, 63, 12);
		queue_req(REQ_READ, 62, 63, 0);
		queue_req(REQ_SEARCH, 0, 0, 12);
		drain();

		// empty on the x axis
		set_window(40, 0, 30, 63);
		queue_req(REQ_WRITE, 35, 5, 4);
		queue_req(REQ_READ, 0, 0, 0);
		queue_req(REQ_SEARCH, 35, 5, 0);
		drain();

		set_window(0, 0, 0, 0);
		queue_req(REQ_READ, 0, 0, 0);
		queue_req(REQ_SEARCH, 63, 63, 15);
		drain();

		set_window(0, 0, 63, 63);
		random_burst(20);
		drain();

		steady = 1'b1;
		random_window(10);
		random_burst(20);
		drain();
		steady = 1'b0;

		set_window($urandom_range(54, 63), $urandom_range(54, 63), 63, 63);
		random_burst(20);
		drain();

		set_window(0, $urandom_range(1, 63), 63, 0);
		random_burst(14);
		drain();

		random_window(12);
		random_burst(20);
		drain();

		random_window(6);
		random_burst(20);
		drain();

		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("PASS grid_nearest_match_search");
		else
			$display("FAIL grid_nearest_match_search");
		$finish;
	end

endmodule
